FILE: src/chcg_pkg.sv
// shared types and constants for the canonical huffman code generator
package chcg_pkg;

   localparam int MAX_CODE_LENGTH_DEF = 16;

   localparam int LENGTH_W = 5;
   localparam int COUNT_W  = 8;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 16;

   localparam logic ACTION_COUNT  = 1'b0;
   localparam logic ACTION_SYMBOL = 1'b1;

   typedef struct packed {
      logic                action;
      logic [LENGTH_W-1:0] code_length;
      logic [COUNT_W-1:0]  length_count;
      logic [SYMBOL_W-1:0] symbol_value;
   } req_beat_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] out_symbol;
      logic [CODE_W-1:0]   code_bits;
      logic [LENGTH_W-1:0] out_length;
      logic                no_code;
   } rsp_beat_type;

   typedef struct packed {
      logic restart;
      logic start;
   } gen_cmd_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic                no_code;
      logic [CODE_W-1:0]   code_bits;
      logic [LENGTH_W-1:0] out_length;
   } gen_stat_type;

endpackage

FILE: src/chcg_stream_if.sv
// valid/ready stream channel carrying one beat of a given payload type
interface chcg_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/chcg_count_store.sv
// per-length symbol count registers with table clear
module chcg_count_store #(
   parameter int DEPTH = chcg_pkg::MAX_CODE_LENGTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_index,
   input  logic [chcg_pkg::COUNT_W-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_index,
   output logic [chcg_pkg::COUNT_W-1:0]     rd_data
);
   logic [chcg_pkg::COUNT_W-1:0] count_ff [DEPTH];
   logic [chcg_pkg::COUNT_W-1:0] count_in [DEPTH];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         count_in[i] = clear ? '0 : count_ff[i];
      end
      if (wr_en) begin
         count_in[wr_index] = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   assign rd_data = (int'(rd_index) < DEPTH) ? count_ff[rd_index] : '0;
endmodule

FILE: src/chcg_code_gen.sv
// sequencer that walks code lengths and hands out canonical codes
module chcg_code_gen #(
   parameter int MAX_CODE_LENGTH = chcg_pkg::MAX_CODE_LENGTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  chcg_pkg::gen_cmd_type                    cmd,
   input  logic [chcg_pkg::COUNT_W-1:0]             count_value,
   output logic [$clog2(MAX_CODE_LENGTH)-1:0]       count_index,
   output chcg_pkg::gen_stat_type                   stat
);
   localparam int IdxW  = $clog2(MAX_CODE_LENGTH);
   localparam int LenW  = $clog2(MAX_CODE_LENGTH + 2);
   localparam int CodeW = MAX_CODE_LENGTH + 1;
   localparam int OutCodeW = chcg_pkg::CODE_W;
   localparam int OutLenW  = chcg_pkg::LENGTH_W;
   localparam logic [LenW-1:0] MaxLen = LenW'(MAX_CODE_LENGTH);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_SCAN = 1'b1;

   logic                         state_ff, state_in;
   logic [LenW-1:0]              cur_len_ff, cur_len_in;
   logic [chcg_pkg::COUNT_W-1:0] used_ff, used_in;
   logic [CodeW-1:0]             next_code_ff, next_code_in;

   logic             in_range;
   logic             skip;
   logic [CodeW-1:0] limit;

   assign in_range    = cur_len_ff <= MaxLen;
   assign skip        = in_range && (used_ff >= count_value);
   assign limit       = {{(CodeW-1){1'b0}}, 1'b1} << cur_len_ff;
   assign count_index = IdxW'(cur_len_ff - LenW'(1));

   always_comb begin
      state_in       = state_ff;
      cur_len_in     = cur_len_ff;
      used_in        = used_ff;
      next_code_in   = next_code_ff;
      stat.busy      = state_ff == STATE_SCAN;
      stat.done      = 1'b0;
      stat.no_code   = 1'b0;
      stat.code_bits = '0;
      stat.out_length = '0;

      case (state_ff)
         STATE_IDLE: begin
            if (cmd.restart) begin
               cur_len_in   = LenW'(1);
               used_in      = '0;
               next_code_in = '0;
            end else if (cmd.start) begin
               state_in = STATE_SCAN;
            end
         end
         STATE_SCAN: begin
            if (skip) begin
               cur_len_in = cur_len_ff + LenW'(1);
               used_in    = '0;
               if (cur_len_ff < MaxLen) begin
                  next_code_in = next_code_ff << 1;
               end
            end else begin
               state_in  = STATE_IDLE;
               stat.done = 1'b1;
               if (!in_range) begin
                  stat.no_code = 1'b1;
               end else begin
                  used_in = used_ff + 1'b1;
                  if (next_code_ff >= limit) begin
                     next_code_in = limit;
                     stat.no_code = 1'b1;
                  end else begin
                     stat.code_bits  = OutCodeW'(next_code_ff[MAX_CODE_LENGTH-1:0]);
                     stat.out_length = OutLenW'(cur_len_ff);
                     next_code_in    = next_code_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         cur_len_ff   <= LenW'(1);
         used_ff      <= '0;
         next_code_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cur_len_ff   <= cur_len_in;
         used_ff      <= used_in;
         next_code_ff <= next_code_in;
      end
   end
endmodule

FILE: src/canonical_huffman_code_generator.sv
// top level of the canonical huffman code generator
//
// req_if carries one beat per table item: a count beat (action 0) gives the
// number of codes of one length, and a count for length 1 starts a new
// table; a symbol beat (action 1) asks for the next canonical code. Count
// beats return nothing. Each symbol beat returns one rsp_if beat with the
// symbol, its code and length, or no_code set when the tree is full or the
// counts are used up.
// A symbol beat is worked on by the single length walker in chcg_code_gen,
// which steps over each used-up length in turn until it reaches a length
// with codes left or runs past MAX_CODE_LENGTH. req_if is not ready while
// a symbol is being worked on.
// The response sits in an output register; req_if stays ready while it is
// being taken, and a stalled receiver holds the block after the current
// beat. Reset clears all counts and restarts at length 1 with code 0;
// no response is pending after reset.
module canonical_huffman_code_generator #(
   parameter int MAX_CODE_LENGTH = chcg_pkg::MAX_CODE_LENGTH_DEF
) (
   input logic           clock,
   input logic           reset,
   chcg_stream_if.sink   req_if,
   chcg_stream_if.source rsp_if
);
   localparam int IdxW = $clog2(MAX_CODE_LENGTH);
   localparam int LenW = chcg_pkg::LENGTH_W;

   chcg_pkg::req_beat_type  req_beat;
   chcg_pkg::rsp_beat_type  rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [chcg_pkg::SYMBOL_W-1:0] symbol_ff, symbol_in;

   chcg_pkg::gen_cmd_type   gen_cmd;
   chcg_pkg::gen_stat_type  gen_stat;
   logic [IdxW-1:0]                count_index;
   logic [chcg_pkg::COUNT_W-1:0]   count_value;

   logic accept;
   logic count_beat;
   logic length_ok;

   assign req_beat      = req_if.payload;
   assign req_if.ready  = !gen_stat.busy && (!rsp_valid_ff || rsp_if.ready);
   assign accept        = req_if.valid && req_if.ready;
   assign count_beat    = accept && (req_beat.action == chcg_pkg::ACTION_COUNT);
   assign length_ok     = (req_beat.code_length >= LenW'(1)) &&
                          (req_beat.code_length <= LenW'(MAX_CODE_LENGTH));

   assign gen_cmd.restart = count_beat && length_ok && (req_beat.code_length == LenW'(1));
   assign gen_cmd.start   = accept && (req_beat.action == chcg_pkg::ACTION_SYMBOL);

   chcg_count_store #(
      .DEPTH (MAX_CODE_LENGTH)
   ) u_count_store (
      .clock    (clock),
      .reset    (reset),
      .clear    (gen_cmd.restart),
      .wr_en    (count_beat && length_ok),
      .wr_index (IdxW'(req_beat.code_length - LenW'(1))),
      .wr_data  (req_beat.length_count),
      .rd_index (count_index),
      .rd_data  (count_value)
   );

   chcg_code_gen #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
   ) u_code_gen (
      .clock       (clock),
      .reset       (reset),
      .cmd         (gen_cmd),
      .count_value (count_value),
      .count_index (count_index),
      .stat        (gen_stat)
   );

   always_comb begin
      symbol_in    = gen_cmd.start ? req_beat.symbol_value : symbol_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      if (gen_stat.done) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.out_symbol = symbol_ff;
         rsp_data_in.code_bits  = gen_stat.code_bits;
         rsp_data_in.out_length = gen_stat.out_length;
         rsp_data_in.no_code    = gen_stat.no_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      symbol_ff   <= symbol_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // a finished code only lands in an empty output register
   a_done_into_empty: assert property (@(posedge clock) disable iff (reset)
      gen_stat.done |-> !rsp_valid_ff)
      else $error("code finished while response still pending");

   // a symbol beat occupies the sequencer next cycle
   a_symbol_starts_scan: assert property (@(posedge clock) disable iff (reset)
      gen_cmd.start |=> gen_stat.busy)
      else $error("symbol beat did not start the sequencer");

   // every finished code shows up as a response
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      gen_stat.done |=> rsp_valid_ff)
      else $error("finished code not presented on rsp");

   // an assigned code is never flagged and never longer than allowed
   a_code_length_ok: assert property (@(posedge clock) disable iff (reset)
      (gen_stat.done && !gen_stat.no_code) |->
         (gen_stat.out_length >= LenW'(1)) &&
         (gen_stat.out_length <= LenW'(MAX_CODE_LENGTH)))
      else $error("assigned code length out of range");
endmodule
